>>> hdl/onlt_pkg.sv
// ----------------------------------------------------------------------------
// onlt_pkg
// Shared types and codes for the ordered name table.
// ----------------------------------------------------------------------------
package onlt_pkg;

  // Operation codes carried on each request.
  localparam logic [2:0] FN_CLEAR  = 3'd0;
  localparam logic [2:0] FN_INSERT = 3'd1;
  localparam logic [2:0] FN_SEARCH = 3'd2;
  localparam logic [2:0] FN_REMOVE = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] name_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] position;
    logic [7:0] entry_count;
    logic       is_empty;
    logic       is_full;
  } out_t;

endpackage

>>> hdl/ordered_name_list_table_unit.sv
// ----------------------------------------------------------------------------
// ordered_name_list_table_unit
// Ordered table of byte-string names with insert, search, remove, clear and query.
// ----------------------------------------------------------------------------
// Name bytes for insert, search and remove arrive one per request; a byte
// without the last mark gives no result. A byte with the last mark starts
// the operation, run by a small sequencer around one byte compare/copy path
// on the name memory; each byte step has a read state and a write or check
// state, since each memory read is registered. Insert copies the name bytes
// into the store. Search compares bytes only on entries whose length
// matches. Remove shifts every later entry down. Clear and query give their
// result from idle. The input is not ready while an operation runs or while
// a result waits to be taken.
module ordered_name_list_table_unit #(
  parameter int ENTRIES    = 128,
  parameter int NAME_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  onlt_pkg::in_t  in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output onlt_pkg::out_t out_rsp
);

  import onlt_pkg::*;

  localparam int KW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int JW  = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int LW  = $clog2(NAME_BYTES + 1);
  localparam int SAW = KW + JW;

  typedef enum logic [3:0] {
    S_IDLE, S_CPY_RD, S_CPY_WR, S_SR_RD, S_SR_LEN,
    S_CMP_RD, S_CMP_CHK, S_SH_RD, S_SH_WR
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic [LW-1:0] len;
  logic          too_long;
  logic [KW-1:0] k;
  logic [KW-1:0] pos;
  logic [JW-1:0] jj;
  logic          rm;
  out_t          res;
  logic          res_valid;

  logic            acc;
  logic            ovf;
  logic            cpy_done;
  logic            cmp_done;
  logic            at_last_entry;
  logic [KW-1:0]   k_inc;

  logic            in_we;
  logic [JW-1:0]   in_waddr;
  logic [JW-1:0]   in_raddr;
  logic [7:0]      in_rdata;
  logic            st_we;
  logic [SAW-1:0]  st_waddr;
  logic [SAW-1:0]  st_raddr;
  logic [7:0]      st_rdata;
  logic            len_we;
  logic [LW-1:0]   len_wdata;
  logic [KW-1:0]   len_raddr;
  logic [LW-1:0]   len_rdata;

  // Builds a result from status, position and count.
  function automatic out_t mk(logic [1:0] st, logic [KW-1:0] p, logic [CW-1:0] c);
    out_t r;
    r.status      = st;
    r.position    = 7'(p);
    r.entry_count = 8'(c);
    r.is_empty    = (c == '0);
    r.is_full     = (c >= CW'(ENTRIES));
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE) && (!res_valid || out_ready);
  assign acc       = in_valid && in_ready;
  assign out_valid = res_valid;
  assign out_rsp   = res;

  // Helper conditions for the sequencer.
  assign ovf           = (len == LW'(NAME_BYTES));
  assign cpy_done      = ((LW'(jj) + LW'(1)) == len);
  assign cmp_done      = cpy_done;
  assign k_inc         = KW'(k + 1'b1);
  assign at_last_entry = ((CW'(k) + CW'(1)) == cnt);

  // Memory addressing and write control.
  always_comb begin
    in_we     = 1'b0;
    in_waddr  = len[JW-1:0];
    in_raddr  = jj;
    st_we     = 1'b0;
    st_waddr  = {k, jj};
    st_raddr  = {k, jj};
    len_we    = 1'b0;
    len_wdata = len;
    len_raddr = k;
    unique case (state)
      S_IDLE: begin
        in_we = acc && !ovf && (in_req.func == FN_INSERT ||
                 in_req.func == FN_SEARCH || in_req.func == FN_REMOVE);
      end
      S_CPY_WR: begin
        st_we  = 1'b1;
        len_we = cpy_done;
      end
      S_SH_RD: begin
        st_raddr  = {k_inc, jj};
        len_raddr = k_inc;
      end
      S_SH_WR: begin
        st_we     = 1'b1;
        len_we    = (jj == '0);
        len_wdata = len_rdata;
      end
      default: begin
      end
    endcase
  end

  onlt_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_incoming (
    .clk(clk), .we(in_we), .waddr(in_waddr), .wdata(in_req.name_byte),
    .raddr(in_raddr), .rdata(in_rdata)
  );

  onlt_ram #(.WIDTH(8), .DEPTH(ENTRIES << JW), .AW(SAW)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr),
    .wdata((state == S_SH_WR) ? st_rdata : in_rdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  onlt_ram #(.WIDTH(LW), .DEPTH(ENTRIES), .AW(KW)) u_lengths (
    .clk(clk), .we(len_we), .waddr(k), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );

  // Sequencer: state, counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      len       <= '0;
      too_long  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (in_req.func) inside
              FN_CLEAR: begin
                cnt       <= '0;
                len       <= '0;
                too_long  <= 1'b0;
                res       <= mk(ST_OK, '0, '0);
                res_valid <= 1'b1;
              end
              FN_QUERY: begin
                res       <= mk(ST_OK, '0, cnt);
                res_valid <= 1'b1;
              end
              FN_INSERT, FN_SEARCH, FN_REMOVE: begin
                if (!ovf) begin
                  len <= len + 1'b1;
                end else begin
                  too_long <= 1'b1;
                end
                if (in_req.last) begin
                  if (too_long || ovf) begin
                    len       <= '0;
                    too_long  <= 1'b0;
                    res       <= mk(ST_TOO_LONG, '0, cnt);
                    res_valid <= 1'b1;
                  end else if (in_req.func == FN_INSERT) begin
                    if (cnt >= CW'(ENTRIES)) begin
                      len       <= '0;
                      res       <= mk(ST_FULL, '0, cnt);
                      res_valid <= 1'b1;
                    end else begin
                      k     <= KW'(cnt);
                      jj    <= '0;
                      state <= S_CPY_RD;
                    end
                  end else if (cnt == '0) begin
                    len       <= '0;
                    res       <= mk(ST_NOTFOUND, '0, cnt);
                    res_valid <= 1'b1;
                  end else begin
                    k     <= '0;
                    rm    <= (in_req.func == FN_REMOVE);
                    state <= S_SR_RD;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CPY_RD: begin
          state <= S_CPY_WR;
        end
        S_CPY_WR: begin
          if (cpy_done) begin
            cnt       <= cnt + 1'b1;
            len       <= '0;
            res       <= mk(ST_OK, k, cnt + 1'b1);
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            jj    <= jj + 1'b1;
            state <= S_CPY_RD;
          end
        end
        S_SR_RD: begin
          state <= S_SR_LEN;
        end
        S_SR_LEN: begin
          if (len_rdata == len) begin
            jj    <= '0;
            state <= S_CMP_RD;
          end else if (at_last_entry) begin
            len       <= '0;
            res       <= mk(ST_NOTFOUND, '0, cnt);
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            k     <= k_inc;
            state <= S_SR_RD;
          end
        end
        S_CMP_RD: begin
          state <= S_CMP_CHK;
        end
        S_CMP_CHK: begin
          if (st_rdata != in_rdata) begin
            if (at_last_entry) begin
              len       <= '0;
              res       <= mk(ST_NOTFOUND, '0, cnt);
              res_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              k     <= k_inc;
              state <= S_SR_RD;
            end
          end else if (cmp_done) begin
            pos <= k;
            len <= '0;
            if (rm && !at_last_entry) begin
              jj    <= '0;
              state <= S_SH_RD;
            end else begin
              if (rm) begin
                cnt <= cnt - 1'b1;
                res <= mk(ST_OK, k, cnt - 1'b1);
              end else begin
                res <= mk(ST_OK, k, cnt);
              end
              res_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            jj    <= jj + 1'b1;
            state <= S_CMP_RD;
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          if (jj == JW'(NAME_BYTES - 1)) begin
            jj <= '0;
            if ((CW'(k_inc) + CW'(1)) == cnt) begin
              cnt       <= cnt - 1'b1;
              res       <= mk(ST_OK, pos, cnt - 1'b1);
              res_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              k     <= k_inc;
              state <= S_SH_RD;
            end
          end else begin
            jj    <= jj + 1'b1;
            state <= S_SH_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The count never passes the capacity.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(ENTRIES))
    else $error("entry count above capacity");

  // A new request is only taken when the result register can be freed.
  a_ready_slot: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!res_valid || out_ready))
    else $error("request taken while a result is stuck");

  // Shifting only runs on entries below the count.
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SH_RD) |-> ((CW'(k) + CW'(1)) < cnt))
    else $error("shift beyond stored entries");

  // A result appears only when the sequencer is in idle.
  a_res_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> (state == S_IDLE))
    else $error("result raised outside idle");
`endif

endmodule

>>> hdl/onlt_ram.sv
// ----------------------------------------------------------------------------
// onlt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module onlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share the clock.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
